// ----- hdl/fih_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fih_pkg: shared types and constants for the frame interval histogram
// Field widths, sequencer states, shared adder request and small helpers.
// ----------------------------------------------------------------------------
package fih_pkg;

    localparam int BUCKETS_DEF = 32;

    localparam int TS_W   = 31;
    localparam int MIN_W  = 14;
    localparam int TOT_W  = 48;
    localparam int CNT_W  = 32;
    localparam int BIDX_W = 6;
    localparam int LIM_W  = 10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 208;
    localparam int M_PAD_W   = M_TDATA_W - (2 * TS_W + MIN_W + TOT_W + 2 * CNT_W
                                            + BIDX_W + LIM_W);

    localparam int                BUCKET_MS = 10;
    localparam logic [MIN_W-1:0]  MIN_START = MIN_W'(9999);

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;
    localparam logic ROW_TICK   = 1'b0;
    localparam logic ROW_BUCKET = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MIN,
        ST_MAX,
        ST_TOT,
        ST_CNT,
        ST_HINC,
        ST_EMIT,
        ST_DUMP_RD,
        ST_DUMP_EMIT
    } fih_state_t;

    // one add or subtract on the shared adder
    typedef struct packed {
        logic [TOT_W-1:0] a;
        logic [TOT_W-1:0] b;
        logic             sub;
    } alu_req_t;

    // x / 10 for x < 640, by reciprocal multiply
    function automatic logic [BIDX_W-1:0] div10_small(input logic [9:0] x);
        logic [17:0] prod;
        prod = {8'b0, x} * 18'd205;
        return prod[16:11];
    endfunction

    // bucket upper bound: 10 * (i + 1)
    function automatic logic [LIM_W-1:0] bucket_limit(input logic [BIDX_W-1:0] i);
        logic [BIDX_W:0] inc;
        logic [10:0]     p;
        inc = {1'b0, i} + 7'd1;
        p   = {4'b0, inc} * 11'd10;
        return p[LIM_W-1:0];
    endfunction

endpackage

// ----- hdl/frame_interval_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_interval_histogram: frame interval statistics with histogram dump
// Tick requests update min/max/total/count and a bucket count; dump requests
// stream out every bucket, clear the histogram and arm a statistics restart.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | content
//  --------+-----+--------------------------------+---------------------------
//  s_      | in  | s_tvalid s_tready s_tdata      | tdata: timestamp_ms[30:0]
//          |     | s_tuser                        | tuser: command
//  m_      | out | m_tvalid m_tready m_tdata      | tdata: report / bucket row
//          |     | m_tuser m_tlast                | tuser: row_kind, tlast: last
//
//  A tick runs through the accept step and seven steps of the shared adder
//  sequence, the last one loading the output register.
//  A dump makes one memory read and one output load per bucket, through
//  the single histogram read port.
//  s_tready is high only while the sequencer is idle; an earlier result may
//  still sit in the output register. A stalled m_ side holds the sequencer
//  at its output step. Reset clears the histogram at once through per-bucket
//  valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module frame_interval_histogram
    import fih_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF   // 2 .. 64
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [30:0] timestamp_ms, [31] zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] command
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [30:0] interval_ms, [44:31] min_interval_ms, [75:45] max_interval_ms,
    // [123:76] total_ms, [155:124] frame_count, [161:156] bucket_index,
    // [171:162] bucket_limit_ms, [203:172] bucket_count, [207:204] zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] row_kind
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int               IDX_W      = $clog2(BUCKETS);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(BUCKETS - 1);
    localparam logic [TS_W-1:0]  LAST_LIMIT = TS_W'(BUCKET_MS * (BUCKETS - 1));

    // sequencer
    fih_state_t state_reg, state_next;

    // statistics state
    logic                 restart_pending_reg;
    logic [TS_W-1:0]      prev_reg;
    logic [MIN_W-1:0]     min_reg;
    logic [TS_W-1:0]      max_reg;
    logic [TOT_W-1:0]     tot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [BUCKETS-1:0]   hist_valid_reg;

    // working registers of the current request
    logic [TS_W-1:0]      now_reg;
    logic [TS_W-1:0]      iv_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     hcount_reg;

    // histogram memory, one read and one write port at idx_reg
    logic [CNT_W-1:0]     hist_mem [BUCKETS];
    logic [CNT_W-1:0]     hist_rd_reg;
    logic [CNT_W-1:0]     hist_cur;
    logic [CNT_W-1:0]     hist_new;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    // control
    logic                 in_fire;
    logic                 emit_ok;
    logic                 dump_last;
    logic                 out_load;
    logic                 out_last;
    logic                 out_kind;
    logic                 hist_we;
    logic                 s_tready_int;
    alu_req_t             alu_req;
    logic [TOT_W:0]       alu_sum;
    logic                 alu_carry;
    logic [IDX_W-1:0]     bkt_calc;
    logic [BIDX_W-1:0]    bidx;
    logic [BIDX_W-1:0]    bq;
    logic [M_TDATA_W-1:0] row_data;

    fih_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign alu_carry = alu_sum[TOT_W];
    assign in_fire   = s_tvalid && s_tready_int;
    // output register is free, or is emptied in this cycle
    assign emit_ok   = !m_tvalid_reg || m_tready;
    assign dump_last = (idx_reg == LAST_IDX);
    assign hist_cur  = hist_valid_reg[idx_reg] ? hist_rd_reg : '0;
    assign hist_new  = alu_sum[CNT_W] ? '1 : alu_sum[CNT_W-1:0];
    assign bidx      = BIDX_W'(idx_reg);

    // bucket of the current interval, long intervals go to the last bucket
    always_comb begin
        bq = div10_small(iv_reg[9:0]);
        if (iv_reg >= LAST_LIMIT) begin
            bkt_calc = LAST_IDX;
        end else begin
            bkt_calc = bq[IDX_W-1:0];
        end
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser == CMD_DUMP) ? ST_DUMP_RD : ST_DIFF;
                end
            end
            ST_DIFF:    state_next = ST_MIN;
            ST_MIN:     state_next = ST_MAX;
            ST_MAX:     state_next = ST_TOT;   // memory read at idx_reg here
            ST_TOT:     state_next = ST_CNT;
            ST_CNT:     state_next = ST_HINC;
            ST_HINC:    state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_ok) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD: state_next = ST_DUMP_EMIT;
            ST_DUMP_EMIT: begin
                if (emit_ok) begin
                    state_next = dump_last ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready_int = 1'b0;
        hist_we      = 1'b0;
        out_load     = 1'b0;
        out_last     = 1'b1;
        out_kind     = ROW_TICK;
        alu_req      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready_int = 1'b1;
            end
            ST_DIFF: begin
                alu_req.a   = TOT_W'(now_reg);
                alu_req.b   = TOT_W'(prev_reg);
                alu_req.sub = 1'b1;
            end
            ST_MIN: begin
                alu_req.a   = TOT_W'(iv_reg);
                alu_req.b   = TOT_W'(min_reg);
                alu_req.sub = 1'b1;
            end
            ST_MAX: begin
                alu_req.a   = TOT_W'(max_reg);
                alu_req.b   = TOT_W'(iv_reg);
                alu_req.sub = 1'b1;
            end
            ST_TOT: begin
                alu_req.a = tot_reg;
                alu_req.b = TOT_W'(iv_reg);
            end
            ST_CNT: begin
                alu_req.a = TOT_W'(cnt_reg);
                alu_req.b = TOT_W'(1);
            end
            ST_HINC: begin
                alu_req.a = TOT_W'(hist_cur);
                alu_req.b = TOT_W'(1);
                hist_we   = 1'b1;
            end
            ST_EMIT: begin
                out_load = emit_ok;
            end
            ST_DUMP_EMIT: begin
                out_load = emit_ok;
                out_last = dump_last;
                out_kind = ROW_BUCKET;
            end
            default: begin
            end
        endcase
    end

    // ---------------- statistics state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            restart_pending_reg <= 1'b1;
            prev_reg            <= '0;
            min_reg             <= MIN_START;
            max_reg             <= '0;
            tot_reg             <= '0;
            cnt_reg             <= '0;
            hist_valid_reg      <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    // restart: the first tick after reset or a dump sees a zero interval
                    if (in_fire && s_tuser == CMD_TICK && restart_pending_reg) begin
                        restart_pending_reg <= 1'b0;
                        prev_reg            <= s_tdata[TS_W-1:0];
                        min_reg             <= MIN_START;
                        max_reg             <= '0;
                        tot_reg             <= '0;
                        cnt_reg             <= '0;
                    end
                end
                ST_DIFF: prev_reg <= now_reg;
                ST_MIN: begin
                    if (!alu_carry) begin
                        min_reg <= iv_reg[MIN_W-1:0];
                    end
                end
                ST_MAX: begin
                    if (!alu_carry) begin
                        max_reg <= iv_reg;
                    end
                end
                ST_TOT: tot_reg <= alu_carry ? '1 : alu_sum[TOT_W-1:0];
                ST_CNT: cnt_reg <= alu_sum[CNT_W] ? '1 : alu_sum[CNT_W-1:0];
                ST_HINC: hist_valid_reg[idx_reg] <= 1'b1;
                ST_DUMP_EMIT: begin
                    if (emit_ok) begin
                        hist_valid_reg[idx_reg] <= 1'b0;
                        if (dump_last) begin
                            restart_pending_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    now_reg <= s_tdata[TS_W-1:0];
                    idx_reg <= '0;
                end
            end
            // negative interval clamps to zero (no carry means now < prev)
            ST_DIFF: iv_reg <= alu_carry ? alu_sum[TS_W-1:0] : '0;
            ST_MIN:  idx_reg <= bkt_calc;
            ST_HINC: hcount_reg <= hist_new;
            ST_DUMP_EMIT: begin
                if (emit_ok && !dump_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- histogram memory ----------------
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[idx_reg] <= hist_new;
        end
        hist_rd_reg <= hist_mem[idx_reg];
    end

    // ---------------- result row ----------------
    always_comb begin
        if (state_reg == ST_EMIT) begin
            row_data = {{M_PAD_W{1'b0}}, hcount_reg, bucket_limit(bidx), bidx,
                        cnt_reg, tot_reg, max_reg, min_reg, iv_reg};
        end else begin
            row_data = {{M_PAD_W{1'b0}}, hist_cur, bucket_limit(bidx), bidx,
                        {CNT_W{1'b0}}, {TOT_W{1'b0}}, {TS_W{1'b0}},
                        {MIN_W{1'b0}}, {TS_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= row_data;
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    assign s_tready = s_tready_int;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register loaded while holding a pending result");

    a_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        min_reg <= MIN_START)
        else $error("minimum above its start value");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (TS_W'(min_reg) <= max_reg))
        else $error("tick report with minimum above maximum");

    a_dump_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP_EMIT && emit_ok && dump_last)
        |=> (restart_pending_reg && hist_valid_reg == '0 && state_reg == ST_IDLE))
        else $error("dump did not clear histogram and arm restart");

    a_tick_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == CMD_TICK) |=> (state_reg == ST_DIFF && !restart_pending_reg))
        else $error("tick did not start the update sequence");

endmodule

// ----- hdl/fih_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fih_alu: shared adder / subtractor
// 48-bit add or subtract with carry out; carry set on subtract means a >= b.
// ----------------------------------------------------------------------------
module fih_alu
    import fih_pkg::*;
(
    input  alu_req_t           req,
    output logic [TOT_W:0]     sum
);

    logic [TOT_W-1:0] b_eff;

    assign b_eff = req.sub ? ~req.b : req.b;
    assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{TOT_W{1'b0}}, req.sub};

endmodule
